// ----- design/ubce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ubce_pkg;

  // Protocol bytes
  localparam logic [7:0] ACK_BYTE  = 8'h79;
  localparam logic [7:0] NACK_BYTE = 8'h1F;
  localparam logic [7:0] SYNC_BYTE = 8'h7F;

  // Command codes
  localparam logic [7:0] CMD_GET     = 8'h00;
  localparam logic [7:0] CMD_VERSION = 8'h01;
  localparam logic [7:0] CMD_ID      = 8'h02;
  localparam logic [7:0] CMD_READ    = 8'h11;
  localparam logic [7:0] CMD_GO      = 8'h21;
  localparam logic [7:0] CMD_WRITE   = 8'h31;
  localparam logic [7:0] CMD_ERASE   = 8'h43;
  localparam logic [7:0] CMD_EXERASE = 8'h44;

  // Special read addresses and limits
  localparam logic [31:0] ADDR_FSIZE  = 32'h1FFF_F7E0;
  localparam logic [31:0] ADDR_PID    = 32'h1FFF_F7D6;
  localparam logic [31:0] ADDR_OPTION = 32'h1FFF_F800;
  localparam logic [15:0] EX_SPECIAL_MIN = 16'hFFF0;
  localparam logic [7:0]  VERSION_BYTE   = 8'h20;
  localparam logic [7:0]  PID_LOW_BYTE   = 8'h05;
  localparam logic [7:0]  OPT_USER_BYTE  = 8'hF0;

  // Input event codes
  localparam logic [1:0] FN_BYTE    = 2'd0;
  localparam logic [1:0] FN_TIMEOUT = 2'd1;
  localparam logic [1:0] FN_DONE    = 2'd2;

  // Result kinds
  localparam logic [2:0] K_SEND  = 3'd0;
  localparam logic [2:0] K_READ  = 3'd1;
  localparam logic [2:0] K_ERASE = 3'd2;
  localparam logic [2:0] K_WRITE = 3'd3;
  localparam logic [2:0] K_JUMP  = 3'd4;

  // Config register indexes
  localparam logic [1:0] REG_FLASH_BASE = 2'd0;
  localparam logic [1:0] REG_FLASH_SIZE = 2'd1;
  localparam logic [1:0] REG_PAGE_SHIFT = 2'd2;

  // Protocol phase; run phases sit at the end
  typedef enum logic [4:0] {
    PH_IDLE, PH_CMD_CRC, PH_ADDR, PH_ADDR_CRC, PH_RD_COUNT, PH_RD_CRC,
    PH_WR_COUNT, PH_DATA, PH_LIST_CRC, PH_ER_COUNT, PH_MASS, PH_EX_COUNT,
    PH_EX_SPECIAL, PH_RUN_OPT, PH_RUN_FILL, PH_RUN_READ, PH_RUN_WRITE,
    PH_RUN_ERASE
  } ph_t;

  // Reply byte sequences
  typedef enum logic [3:0] {
    SQ_NONE, SQ_ACK, SQ_NACK, SQ_GET, SQ_VER, SQ_ID, SQ_SIZE, SQ_PID,
    SQ_ACK_B, SQ_B
  } seq_t;

  // Request that follows the reply bytes
  typedef enum logic [2:0] {
    TL_NONE, TL_JUMP, TL_READ, TL_WRITE, TL_ERASE
  } tail_t;

  // Result sequencer state
  typedef enum logic [1:0] {
    JS_IDLE, JS_BYTES, JS_FETCH, JS_TAIL
  } js_t;

  typedef struct packed {
    seq_t       seq;
    logic [7:0] data8;
    tail_t      tail;
  } job_t;

  function automatic logic [3:0] seq_len(input seq_t s);
    logic [3:0] n;
    unique case (s)
      SQ_GET:                   n = 4'd11;
      SQ_VER, SQ_ID:            n = 4'd5;
      SQ_SIZE, SQ_PID:          n = 4'd3;
      SQ_ACK_B:                 n = 4'd2;
      SQ_ACK, SQ_NACK, SQ_B:    n = 4'd1;
      default:                  n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] get_byte(input logic [3:0] i);
    logic [7:0] v;
    unique case (i)
      4'd0:    v = ACK_BYTE;
      4'd1:    v = 8'h07;
      4'd2:    v = 8'h20;
      4'd3:    v = CMD_GET;
      4'd4:    v = CMD_VERSION;
      4'd5:    v = CMD_ID;
      4'd6:    v = CMD_READ;
      4'd7:    v = CMD_GO;
      4'd8:    v = CMD_WRITE;
      4'd9:    v = CMD_EXERASE;
      default: v = ACK_BYTE;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] seq_byte(input seq_t s, input logic [3:0] i,
                                          input logic [7:0] b,
                                          input logic [24:0] fsize);
    logic [7:0] v;
    v = ACK_BYTE;
    unique case (s)
      SQ_NACK: v = NACK_BYTE;
      SQ_GET:  v = get_byte(i);
      SQ_VER: begin
        if (i == 4'd1) v = VERSION_BYTE;
        else if (i == 4'd2 || i == 4'd3) v = 8'h00;
      end
      SQ_ID: begin
        if (i == 4'd1) v = 8'h01;
        else if (i == 4'd2) v = PID_LOW_BYTE;
        else if (i == 4'd3) v = 8'h20;
      end
      SQ_SIZE: begin
        if (i == 4'd1) v = fsize[17:10];
        else if (i == 4'd2) v = {1'b0, fsize[24:18]};
      end
      SQ_PID: begin
        if (i == 4'd1) v = 8'h20;
        else if (i == 4'd2) v = 8'h00;
      end
      SQ_ACK_B: if (i == 4'd1) v = b;
      SQ_B:     v = b;
      default:  v = ACK_BYTE;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] opt_byte(input logic [3:0] i);
    logic [7:0] v;
    if (i < 4'd8) v = 8'h00;
    else if (i == 4'd8) v = OPT_USER_BYTE;
    else v = 8'hFF;
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/ubce_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- design/uart_bootloader_command_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Serial bootloader command engine.
// Input channel (in_*): one beat per host byte, receive timeout or
// "request done" event. Output channel (out_*): reply bytes for the host and
// memory requests (read byte, erase page, write word, jump); out_last marks
// the final result caused by one input beat.
// Config channel (cfg_*), always ready: flash base, flash size and page shift,
// written by index; the user must write them only while the engine is idle,
// as the engine does not enforce it. Derived flash end and page count are registered.
// Sequencing: an accepted beat's job is registered, then its results enter the
// output register one per cycle while the register is free. Write and erase
// requests first read their payload from the buffer RAM: 1, 2 or 4 reads at
// one per cycle through its registered read port.
// Throughput: a beat with no result leaves the single result sequencer idle;
// a beat with results, and any payload reads, holds off the next beat until
// the sequencer has queued them all.
// Reset: synchronous, active low; back to waiting for a command byte with
// default config. The buffer RAM is not cleared.
// Output stall: results wait in the output register; the engine accepts a new
// beat as soon as the previous beat's results are all queued.
module uart_bootloader_command_engine_core
  import ubce_pkg::*;
#(
  parameter int BUFFER_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [7:0]  in_read_data,
  input  wire logic        in_op_ok,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_tx_byte,
  output logic [31:0]      out_mem_address,
  output logic [31:0]      out_mem_word,
  output logic             out_last
);

  localparam int AW = $clog2(BUFFER_BYTES);

  // Config and derived values
  logic [31:0] base_r;
  logic [24:0] size_r;
  logic [4:0]  shift_r;
  logic [32:0] end_r;
  logic [24:0] pages_r;

  // Protocol state
  ph_t         phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  cs_r, cs_nxt;
  logic [31:0] ta_r, ta_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] idx_r, idx_nxt;

  // Result sequencer
  js_t         js_r, js_nxt;
  job_t        job_r, job_nxt;
  logic [3:0]  bcnt_r, bcnt_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [2:0]  rcv_r, rcv_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [31:0] w_r, w_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  txb_r, txb_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] word_r, word_nxt;
  logic        last_r, last_nxt;

  // Buffer RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  ubce_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_rx_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  logic acc;
  assign in_ready  = (js_r == JS_IDLE);
  assign acc       = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  // Checks used by the byte handler
  logic [7:0]  cs_x;
  logic [15:0] idx_inc;
  logic [16:0] lst_bytes;
  logic [16:0] wr_n;
  logic [15:0] c2;
  logic        go_ok, rd_in, wr_ok, er_ok, ex_big;

  always_comb begin
    cs_x      = cs_r ^ in_rx_byte;
    idx_inc   = idx_r + 16'd1;
    lst_bytes = (cmd_r == CMD_EXERASE) ? ({cnt_r, 1'b0} + 17'd2) :
                                         ({1'b0, cnt_r} + 17'd1);
    wr_n      = {1'b0, cnt_r} + 17'd1;
    c2        = {cnt_r[7:0], in_rx_byte};
    go_ok     = (ta_r >= base_r) && ({1'b0, ta_r} < end_r);
    rd_in     = ({1'b0, ta_r} + 33'(cnt_r) + 33'd1) < end_r;
    wr_ok     = (wr_n[1:0] == 2'b00) && ({1'b0, ta_r} < end_r) &&
                (({1'b0, ta_r} + 33'(wr_n)) < end_r);
    er_ok     = (25'(in_rx_byte) + 25'd1) < pages_r;
    ex_big    = ({1'b0, c2, 1'b0} + 18'd2) > 18'(BUFFER_BYTES);
  end

  // Input beat handling: protocol state update and job selection
  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    cs_nxt    = cs_r;
    ta_nxt    = ta_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    job_nxt   = '{seq: SQ_NONE, data8: 8'h00, tail: TL_NONE};
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    if (acc) begin
      if (phase_r == PH_IDLE) begin
        if (in_func == FN_BYTE) begin
          if (in_rx_byte == ACK_BYTE || in_rx_byte == NACK_BYTE) begin
            cs_nxt = 8'hFF;
          end else if (in_rx_byte == SYNC_BYTE) begin
            job_nxt.seq = SQ_ACK;
            cs_nxt      = 8'hFF;
          end else begin
            cs_nxt    = ~in_rx_byte;
            cmd_nxt   = in_rx_byte;
            phase_nxt = PH_CMD_CRC;
          end
        end
      end else if (phase_r >= PH_RUN_OPT) begin
        if (in_func == FN_DONE) begin
          priority case (phase_r)
            PH_RUN_OPT, PH_RUN_FILL: begin
              job_nxt.seq   = SQ_B;
              job_nxt.data8 = (phase_r == PH_RUN_OPT) ? opt_byte(idx_r[3:0]) : 8'hFF;
              idx_nxt       = idx_inc;
              if (idx_inc > cnt_r) begin
                phase_nxt = PH_IDLE;
                cs_nxt    = 8'hFF;
              end
            end
            PH_RUN_READ: begin
              job_nxt.seq   = SQ_B;
              job_nxt.data8 = in_read_data;
              idx_nxt       = idx_inc;
              if (idx_inc > cnt_r) begin
                phase_nxt = PH_IDLE;
                cs_nxt    = 8'hFF;
              end else begin
                job_nxt.tail = TL_READ;
              end
            end
            PH_RUN_WRITE, PH_RUN_ERASE: begin
              if (!in_op_ok) begin
                job_nxt.seq = SQ_NACK;
                phase_nxt   = PH_IDLE;
                cs_nxt      = 8'hFF;
              end else begin
                idx_nxt = idx_inc;
                if ((phase_r == PH_RUN_WRITE && {idx_inc, 2'b00} >= 18'(wr_n)) ||
                    (phase_r == PH_RUN_ERASE && idx_inc > cnt_r)) begin
                  job_nxt.seq = SQ_ACK;
                  phase_nxt   = PH_IDLE;
                  cs_nxt      = 8'hFF;
                end else begin
                  job_nxt.tail = (phase_r == PH_RUN_WRITE) ? TL_WRITE : TL_ERASE;
                end
              end
            end
            default: ;
          endcase
        end
      end else if (in_func == FN_TIMEOUT) begin
        job_nxt.seq = SQ_NACK;
        phase_nxt   = PH_IDLE;
        cs_nxt      = 8'hFF;
      end else if (in_func == FN_BYTE) begin
        cs_nxt = cs_x;
        case (phase_r)
          PH_CMD_CRC: begin
            if (cs_x != 8'h00) begin
              job_nxt.seq = SQ_NACK;
              phase_nxt   = PH_IDLE;
              cs_nxt      = 8'hFF;
            end else begin
              case (cmd_r)
                CMD_GET, CMD_VERSION, CMD_ID: begin
                  job_nxt.seq = (cmd_r == CMD_GET) ? SQ_GET :
                                (cmd_r == CMD_VERSION) ? SQ_VER : SQ_ID;
                  phase_nxt   = PH_IDLE;
                  cs_nxt      = 8'hFF;
                end
                CMD_READ, CMD_GO, CMD_WRITE: begin
                  job_nxt.seq = SQ_ACK;
                  cs_nxt      = 8'h00;
                  ta_nxt      = 32'h0;
                  idx_nxt     = 16'h0;
                  phase_nxt   = PH_ADDR;
                end
                CMD_ERASE: begin
                  job_nxt.seq = SQ_ACK;
                  cs_nxt      = 8'h00;
                  phase_nxt   = PH_ER_COUNT;
                end
                CMD_EXERASE: begin
                  job_nxt.seq = SQ_ACK;
                  cs_nxt      = 8'h00;
                  cnt_nxt     = 16'h0;
                  idx_nxt     = 16'h0;
                  phase_nxt   = PH_EX_COUNT;
                end
                default: begin
                  job_nxt.seq = SQ_NACK;
                  phase_nxt   = PH_IDLE;
                  cs_nxt      = 8'hFF;
                end
              endcase
            end
          end
          PH_ADDR: begin
            ta_nxt  = {ta_r[23:0], in_rx_byte};
            idx_nxt = idx_inc;
            if (idx_inc >= 16'd4) phase_nxt = PH_ADDR_CRC;
          end
          PH_ADDR_CRC: begin
            if (cs_x != 8'h00) begin
              job_nxt.seq = SQ_NACK;
              phase_nxt   = PH_IDLE;
              cs_nxt      = 8'hFF;
            end else begin
              job_nxt.seq = SQ_ACK;
              if (cmd_r == CMD_GO) begin
                if (go_ok) job_nxt.tail = TL_JUMP;
                phase_nxt = PH_IDLE;
                cs_nxt    = 8'hFF;
              end else if (cmd_r == CMD_WRITE) begin
                cs_nxt    = 8'h00;
                phase_nxt = PH_WR_COUNT;
              end else begin
                cs_nxt    = 8'hFF;
                phase_nxt = PH_RD_COUNT;
              end
            end
          end
          PH_RD_COUNT: begin
            cnt_nxt   = {8'h00, in_rx_byte};
            phase_nxt = PH_RD_CRC;
          end
          PH_RD_CRC: begin
            if (cs_x != 8'h00) begin
              job_nxt.seq = SQ_NACK;
              phase_nxt   = PH_IDLE;
              cs_nxt      = 8'hFF;
            end else if (ta_r == ADDR_FSIZE && cnt_r == 16'd1) begin
              job_nxt.seq = SQ_SIZE;
              phase_nxt   = PH_IDLE;
              cs_nxt      = 8'hFF;
            end else if (ta_r == ADDR_PID && cnt_r == 16'd1) begin
              job_nxt.seq = SQ_PID;
              phase_nxt   = PH_IDLE;
              cs_nxt      = 8'hFF;
            end else if (ta_r == ADDR_OPTION && cnt_r == 16'h000F) begin
              job_nxt.seq   = SQ_ACK_B;
              job_nxt.data8 = opt_byte(4'd0);
              idx_nxt       = 16'd1;
              phase_nxt     = PH_RUN_OPT;
            end else if (rd_in) begin
              job_nxt.seq  = SQ_ACK;
              job_nxt.tail = TL_READ;
              idx_nxt      = 16'd0;
              phase_nxt    = PH_RUN_READ;
            end else begin
              // out of range: answer 0xFF bytes
              job_nxt.seq   = SQ_ACK_B;
              job_nxt.data8 = 8'hFF;
              idx_nxt       = 16'd1;
              if (cnt_r == 16'd0) begin
                phase_nxt = PH_IDLE;
                cs_nxt    = 8'hFF;
              end else begin
                phase_nxt = PH_RUN_FILL;
              end
            end
          end
          PH_WR_COUNT: begin
            cnt_nxt   = {8'h00, in_rx_byte};
            idx_nxt   = 16'd0;
            phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            ram_we  = ({1'b0, idx_r} < 17'(BUFFER_BYTES));
            idx_nxt = idx_inc;
            if ({1'b0, idx_inc} >= lst_bytes) phase_nxt = PH_LIST_CRC;
          end
          PH_LIST_CRC: begin
            idx_nxt = 16'd0;
            if (cs_x != 8'h00) begin
              job_nxt.seq = SQ_NACK;
              phase_nxt   = PH_IDLE;
              cs_nxt      = 8'hFF;
            end else if (cmd_r == CMD_WRITE) begin
              if (wr_ok) begin
                job_nxt.tail = TL_WRITE;
                phase_nxt    = PH_RUN_WRITE;
              end else begin
                job_nxt.seq = SQ_NACK;
                phase_nxt   = PH_IDLE;
                cs_nxt      = 8'hFF;
              end
            end else begin
              job_nxt.tail = TL_ERASE;
              phase_nxt    = PH_RUN_ERASE;
            end
          end
          PH_ER_COUNT: begin
            if (in_rx_byte == 8'hFF) begin
              phase_nxt = PH_MASS;
            end else if (er_ok) begin
              cnt_nxt   = {8'h00, in_rx_byte};
              idx_nxt   = 16'd0;
              phase_nxt = PH_DATA;
            end else begin
              job_nxt.seq = SQ_NACK;
              phase_nxt   = PH_IDLE;
              cs_nxt      = 8'hFF;
            end
          end
          PH_MASS: begin
            job_nxt.seq = (in_rx_byte == 8'h00) ? SQ_ACK : SQ_NACK;
            phase_nxt   = PH_IDLE;
            cs_nxt      = 8'hFF;
          end
          PH_EX_COUNT: begin
            cnt_nxt = c2;
            idx_nxt = idx_inc;
            if (idx_inc >= 16'd2) begin
              idx_nxt = 16'd0;
              if (c2 >= EX_SPECIAL_MIN) begin
                phase_nxt = PH_EX_SPECIAL;
              end else if (ex_big) begin
                job_nxt.seq = SQ_NACK;
                phase_nxt   = PH_IDLE;
                cs_nxt      = 8'hFF;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
          PH_EX_SPECIAL: begin
            job_nxt.seq = SQ_ACK;
            phase_nxt   = PH_IDLE;
            cs_nxt      = 8'hFF;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload fetch geometry
  logic [17:0] fbase;
  logic [2:0]  fneed;
  logic [15:0] page;
  logic [3:0]  blen;
  logic        slot_free;

  always_comb begin
    if (cmd_r == CMD_WRITE) begin
      fbase = {idx_r, 2'b00};
      fneed = 3'd4;
    end else if (cmd_r == CMD_EXERASE) begin
      fbase = {1'b0, idx_r, 1'b0};
      fneed = 3'd2;
    end else begin
      fbase = {2'b00, idx_r};
      fneed = 3'd1;
    end
    page      = (cmd_r == CMD_EXERASE) ? {w_r[23:16], w_r[31:24]} : {8'h00, w_r[31:24]};
    blen      = seq_len(job_r.seq);
    slot_free = !out_valid_r || out_ready;
    ram_re    = (js_r == JS_FETCH) && (fcnt_r < fneed);
    ram_raddr = AW'(fbase + 18'(fcnt_r));
  end

  // Result sequencer: reply bytes, payload reads, then the request
  always_comb begin
    js_nxt        = js_r;
    bcnt_nxt      = bcnt_r;
    fcnt_nxt      = fcnt_r;
    rcv_nxt       = rcv_r;
    rd_pend_nxt   = 1'b0;
    w_nxt         = w_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    txb_nxt       = txb_r;
    addr_nxt      = addr_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    unique case (js_r)
      JS_IDLE: begin
        if (acc) begin
          bcnt_nxt = 4'd0;
          fcnt_nxt = 3'd0;
          rcv_nxt  = 3'd0;
          if (job_nxt.seq != SQ_NONE) js_nxt = JS_BYTES;
          else if (job_nxt.tail == TL_WRITE || job_nxt.tail == TL_ERASE) js_nxt = JS_FETCH;
          else if (job_nxt.tail != TL_NONE) js_nxt = JS_TAIL;
        end
      end
      JS_BYTES: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = K_SEND;
          txb_nxt       = seq_byte(job_r.seq, bcnt_r, job_r.data8, size_r);
          addr_nxt      = 32'h0;
          word_nxt      = 32'h0;
          last_nxt      = (bcnt_r == blen - 4'd1) && (job_r.tail == TL_NONE);
          bcnt_nxt      = bcnt_r + 4'd1;
          if (bcnt_r == blen - 4'd1) begin
            priority case (job_r.tail)
              TL_NONE:            js_nxt = JS_IDLE;
              TL_WRITE, TL_ERASE: js_nxt = JS_FETCH;
              default:            js_nxt = JS_TAIL;
            endcase
          end
        end
      end
      JS_FETCH: begin
        if (ram_re) begin
          fcnt_nxt    = fcnt_r + 3'd1;
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          w_nxt   = {ram_rdata, w_r[31:8]};
          rcv_nxt = rcv_r + 3'd1;
          if (rcv_r + 3'd1 == fneed) js_nxt = JS_TAIL;
        end
      end
      JS_TAIL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          txb_nxt       = 8'h00;
          word_nxt      = 32'h0;
          last_nxt      = 1'b1;
          js_nxt        = JS_IDLE;
          unique case (job_r.tail)
            TL_JUMP: begin
              kind_nxt = K_JUMP;
              addr_nxt = ta_r;
            end
            TL_READ: begin
              kind_nxt = K_READ;
              addr_nxt = ta_r + 32'(idx_r);
            end
            TL_WRITE: begin
              kind_nxt = K_WRITE;
              addr_nxt = ta_r + {14'h0, idx_r, 2'b00};
              word_nxt = w_r;
            end
            default: begin
              kind_nxt = K_ERASE;
              addr_nxt = base_r + (32'(page) << shift_r);
            end
          endcase
        end
      end
      default: js_nxt = JS_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= 32'h0;
      size_r      <= 25'd131072;
      shift_r     <= 5'd9;
      end_r       <= 33'd131072;
      pages_r     <= 25'd256;
      phase_r     <= PH_IDLE;
      cmd_r       <= 8'h00;
      cs_r        <= 8'hFF;
      ta_r        <= 32'h0;
      cnt_r       <= 16'h0;
      idx_r       <= 16'h0;
      js_r        <= JS_IDLE;
      job_r       <= '{seq: SQ_NONE, data8: 8'h00, tail: TL_NONE};
      bcnt_r      <= 4'd0;
      fcnt_r      <= 3'd0;
      rcv_r       <= 3'd0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FLASH_BASE) base_r <= cfg_data;
        if (cfg_index == REG_FLASH_SIZE) size_r <= cfg_data[24:0];
        if (cfg_index == REG_PAGE_SHIFT) shift_r <= cfg_data[4:0];
      end
      end_r       <= {1'b0, base_r} + 33'(size_r);
      pages_r     <= size_r >> shift_r;
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      cs_r        <= cs_nxt;
      ta_r        <= ta_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      js_r        <= js_nxt;
      if (acc) job_r <= job_nxt;
      bcnt_r      <= bcnt_nxt;
      fcnt_r      <= fcnt_nxt;
      rcv_r       <= rcv_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    kind_r <= kind_nxt;
    txb_r  <= txb_nxt;
    addr_r <= addr_nxt;
    word_r <= word_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_tx_byte     = txb_r;
  assign out_mem_address = addr_r;
  assign out_mem_word    = word_r;
  assign out_last        = last_r;

  // Buffer writes never overlap a payload fetch
  a_no_wr_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (js_r == JS_IDLE))
    else $error("buffer write while sequencer busy");

  // Sequencer leaves idle only on an accepted beat
  a_job_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (js_r == JS_IDLE && !acc) |=> (js_r == JS_IDLE))
    else $error("sequencer started without an input beat");

  // Requests always close a beat's results
  a_req_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != K_SEND) |-> out_last)
    else $error("request not marked last");

  // Fetch never collects more bytes than needed
  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (js_r == JS_FETCH) |-> (rcv_r < fneed && fcnt_r <= fneed))
    else $error("payload fetch overrun");

endmodule
`default_nettype wire

// ----- bench/tb_uart_bootloader_command_engine_core.sv -----
`timescale 1ns / 1ps
module tb_uart_bootloader_command_engine_core
  import ubce_pkg::*;
();

  localparam int STORE_BYTES = 2048;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  tx;
    logic [31:0] addr;
    logic [31:0] word;
    logic        last;
  } reply_t;

  // Engine predictor plus the queue of replies and requests still owed
  class boot_scoreboard;
    logic [31:0] base = 32'd0;
    logic [24:0] fsize = 25'd131072;
    logic [4:0]  pshift = 5'd9;
    ph_t         ph = PH_IDLE;
    logic [7:0]  cmd = 8'd0;
    logic [7:0]  crc = 8'hFF;
    logic [31:0] tgt = 32'd0;
    logic [15:0] cnt = 16'd0;
    logic [15:0] idx = 16'd0;
    logic [7:0]  store [STORE_BYTES];
    reply_t      owed [$];

    function void set_reg(logic [1:0] r, logic [31:0] v);
      if (r == REG_FLASH_BASE) base = v;
      else if (r == REG_FLASH_SIZE) fsize = v[24:0];
      else if (r == REG_PAGE_SHIFT) pshift = v[4:0];
    endfunction

    function longint unsigned fend();
      return longint'(base) + longint'(fsize);
    endfunction

    function logic [7:0] sbyte(int unsigned i);
      return (i < STORE_BYTES) ? store[i] : 8'd0;
    endfunction

    function void emit(logic [2:0] k, logic [7:0] b, logic [31:0] a, logic [31:0] w);
      reply_t r;
      r.kind = k; r.tx = b; r.addr = a; r.word = w; r.last = 1'b0;
      owed.push_back(r);
    endfunction

    function void tx(logic [7:0] b);
      emit(K_SEND, b, 32'd0, 32'd0);
    endfunction

    function void close(logic [7:0] b);
      tx(b);
      ph = PH_IDLE;
      crc = 8'hFF;
    endfunction

    function void erase_req();
      logic [31:0] page;
      if (cmd == CMD_EXERASE) page = 32'({sbyte(2 * idx), sbyte(2 * idx + 1)});
      else page = 32'(sbyte(idx));
      emit(K_ERASE, 8'd0, base + (page << pshift), 32'd0);
    endfunction

    function void write_req();
      int unsigned b;
      b = 4 * idx;
      emit(K_WRITE, 8'd0, tgt + b,
           {sbyte(b + 3), sbyte(b + 2), sbyte(b + 1), sbyte(b)});
    endfunction

    // option bytes or 0xFF filler, one per step
    function void const_byte();
      logic [3:0] o;
      o = idx[3:0];
      if (ph == PH_RUN_OPT) tx(o < 8 ? 8'h00 : (o == 8 ? OPT_USER_BYTE : 8'hFF));
      else tx(8'hFF);
      idx++;
      if (idx > cnt) begin
        ph = PH_IDLE; crc = 8'hFF;
      end
    endfunction

    function void dispatch();
      logic [7:0] get_list [8] = '{8'h20, CMD_GET, CMD_VERSION, CMD_ID,
                                   CMD_READ, CMD_GO, CMD_WRITE, CMD_EXERASE};
      case (cmd)
        CMD_GET: begin
          tx(ACK_BYTE); tx(8'h07);
          foreach (get_list[i]) tx(get_list[i]);
          close(ACK_BYTE);
        end
        CMD_VERSION: begin
          tx(ACK_BYTE); tx(VERSION_BYTE); tx(8'h00); tx(8'h00); close(ACK_BYTE);
        end
        CMD_ID: begin
          tx(ACK_BYTE); tx(8'h01); tx(PID_LOW_BYTE); tx(8'h20); close(ACK_BYTE);
        end
        CMD_READ, CMD_GO, CMD_WRITE: begin
          tx(ACK_BYTE); crc = 8'h00; tgt = 32'd0; idx = 16'd0; ph = PH_ADDR;
        end
        CMD_ERASE: begin
          tx(ACK_BYTE); crc = 8'h00; ph = PH_ER_COUNT;
        end
        CMD_EXERASE: begin
          tx(ACK_BYTE); crc = 8'h00; cnt = 16'd0; idx = 16'd0; ph = PH_EX_COUNT;
        end
        default: close(NACK_BYTE);
      endcase
    endfunction

    function void addr_done();
      tx(ACK_BYTE);
      if (cmd == CMD_GO) begin
        if (tgt >= base && longint'(tgt) < fend()) emit(K_JUMP, 8'd0, tgt, 32'd0);
        ph = PH_IDLE; crc = 8'hFF;
      end else if (cmd == CMD_WRITE) begin
        crc = 8'h00; ph = PH_WR_COUNT;
      end else begin
        crc = 8'hFF; ph = PH_RD_COUNT;
      end
    endfunction

    function void read_go();
      tx(ACK_BYTE);
      if (tgt == ADDR_FSIZE && cnt == 1) begin
        tx(fsize[17:10]);
        close({1'b0, fsize[24:18]});
      end else if (tgt == ADDR_PID && cnt == 1) begin
        tx(8'h20);
        close(8'h00);
      end else begin
        idx = 16'd0;
        if (tgt == ADDR_OPTION && cnt == 16'h0F) begin
          ph = PH_RUN_OPT; const_byte();
        end else if (longint'(tgt) + cnt + 1 < fend()) begin
          ph = PH_RUN_READ; emit(K_READ, 8'd0, tgt, 32'd0);
        end else begin
          ph = PH_RUN_FILL; const_byte();
        end
      end
    endfunction

    function void list_done();
      int unsigned n;
      idx = 16'd0;
      if (cmd == CMD_WRITE) begin
        n = cnt + 1;
        if (n % 4 == 0 && longint'(tgt) < fend() && longint'(tgt) + n < fend()) begin
          ph = PH_RUN_WRITE; write_req();
        end else close(NACK_BYTE);
      end else begin
        ph = PH_RUN_ERASE; erase_req();
      end
    endfunction

    function void host_byte(logic [7:0] b);
      int unsigned lb;
      case (ph)
        PH_CMD_CRC: begin
          crc ^= b;
          if (crc != 0) close(NACK_BYTE); else dispatch();
        end
        PH_ADDR: begin
          crc ^= b; tgt = {tgt[23:0], b}; idx++;
          if (idx >= 4) ph = PH_ADDR_CRC;
        end
        PH_ADDR_CRC: begin
          crc ^= b;
          if (crc != 0) close(NACK_BYTE); else addr_done();
        end
        PH_RD_COUNT: begin
          crc ^= b; cnt = 16'(b); ph = PH_RD_CRC;
        end
        PH_RD_CRC: begin
          crc ^= b;
          if (crc != 0) close(NACK_BYTE); else read_go();
        end
        PH_WR_COUNT: begin
          crc ^= b; cnt = 16'(b); idx = 16'd0; ph = PH_DATA;
        end
        PH_DATA: begin
          crc ^= b;
          if (idx < STORE_BYTES) store[idx] = b;
          idx++;
          lb = (cmd == CMD_EXERASE) ? 2 * (cnt + 1) : cnt + 1;
          if (idx >= lb) ph = PH_LIST_CRC;
        end
        PH_LIST_CRC: begin
          crc ^= b;
          if (crc != 0) close(NACK_BYTE); else list_done();
        end
        PH_ER_COUNT: begin
          crc ^= b;
          if (b == 8'hFF) ph = PH_MASS;
          else if (int'(b) < int'(fsize >> pshift) - 1) begin
            cnt = 16'(b); idx = 16'd0; ph = PH_DATA;
          end else close(NACK_BYTE);
        end
        PH_MASS: close(b == 0 ? ACK_BYTE : NACK_BYTE);
        PH_EX_COUNT: begin
          crc ^= b; cnt = {cnt[7:0], b}; idx++;
          if (idx >= 2) begin
            idx = 16'd0;
            if (cnt >= EX_SPECIAL_MIN) ph = PH_EX_SPECIAL;
            else if (2 * (int'(cnt) + 1) > STORE_BYTES) close(NACK_BYTE);
            else ph = PH_DATA;
          end
        end
        PH_EX_SPECIAL: close(ACK_BYTE);
        default: ;
      endcase
    endfunction

    function void done_event(logic [7:0] rd, logic ok);
      case (ph)
        PH_RUN_OPT, PH_RUN_FILL: const_byte();
        PH_RUN_READ: begin
          tx(rd); idx++;
          if (idx > cnt) begin
            ph = PH_IDLE; crc = 8'hFF;
          end else emit(K_READ, 8'd0, tgt + idx, 32'd0);
        end
        PH_RUN_WRITE: begin
          if (!ok) close(NACK_BYTE);
          else begin
            idx++;
            if (4 * int'(idx) >= int'(cnt) + 1) close(ACK_BYTE); else write_req();
          end
        end
        PH_RUN_ERASE: begin
          if (!ok) close(NACK_BYTE);
          else begin
            idx++;
            if (idx > cnt) close(ACK_BYTE); else erase_req();
          end
        end
        default: ;
      endcase
    endfunction

    // accepted input beat
    function void note_beat(logic [1:0] f, logic [7:0] b, logic [7:0] rd, logic ok);
      int n0;
      n0 = owed.size();
      if (ph == PH_IDLE) begin
        if (f == FN_BYTE) begin
          if (b == ACK_BYTE || b == NACK_BYTE) crc = 8'hFF;
          else if (b == SYNC_BYTE) close(ACK_BYTE);
          else begin
            crc = 8'hFF ^ b; cmd = b; ph = PH_CMD_CRC;
          end
        end
      end else if (ph >= PH_RUN_OPT) begin
        if (f == FN_DONE) done_event(rd, ok);
      end else if (f == FN_TIMEOUT) close(NACK_BYTE);
      else if (f == FN_BYTE) host_byte(b);
      if (owed.size() > n0) owed[owed.size() - 1].last = 1'b1;
    endfunction

    // accepted result beat; empty string when it matches
    function string check_result(logic [2:0] k, logic [7:0] t, logic [31:0] a,
                                 logic [31:0] w, logic l);
      reply_t e;
      if (owed.size() == 0)
        return $sformatf("unexpected result kind=%0d tx=%02h addr=%08h", k, t, a);
      e = owed.pop_front();
      if (k !== e.kind || t !== e.tx || a !== e.addr || w !== e.word || l !== e.last)
        return $sformatf({"got k=%0d tx=%02h a=%08h w=%08h l=%0b, ",
                          "want k=%0d tx=%02h a=%08h w=%08h l=%0b"},
                         k, t, a, w, l, e.kind, e.tx, e.addr, e.word, e.last);
      return "";
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_func = 2'd0;
  logic [7:0]  in_rx_byte = 8'd0;
  logic [7:0]  in_read_data = 8'd0;
  logic        in_op_ok = 1'b0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [2:0]  out_kind;
  wire  [7:0]  out_tx_byte;
  wire  [31:0] out_mem_address;
  wire  [31:0] out_mem_word;
  wire         out_last;

  uart_bootloader_command_engine_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_rx_byte(in_rx_byte), .in_read_data(in_read_data), .in_op_ok(in_op_ok),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_tx_byte(out_tx_byte), .out_mem_address(out_mem_address),
    .out_mem_word(out_mem_word), .out_last(out_last)
  );

  boot_scoreboard sb = new();
  int errors = 0;
  int beats = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // receiver: always ready, random, or one cycle in four
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (stall_tick % 4 == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      msg = sb.check_result(out_kind, out_tx_byte, out_mem_address, out_mem_word, out_last);
      if (msg != "") report(msg);
    end
  end

  // watchdog on channels that stop moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one input beat, bursts with random gaps
  task automatic put(input logic [1:0] f, input logic [7:0] b);
    logic [7:0] rd;
    logic ok;
    rd = 8'($urandom_range(0, 255));
    ok = ($urandom_range(0, 9) != 0);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_rx_byte <= b;
    in_read_data <= rd;
    in_op_ok <= ok;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(f, b, rd, ok);
    burst_left--;
    beats++;
  endtask

  task automatic host(input logic [7:0] b);
    put(FN_BYTE, b);
  endtask

  function automatic bit flaw();
    return $urandom_range(0, 15) == 0;
  endfunction

  task automatic send_crc(input logic [7:0] c);
    host(flaw() ? c ^ (8'h1 << $urandom_range(0, 7)) : c);
  endtask

  task automatic command(input logic [7:0] c);
    host(c);
    send_crc(~c);
  endtask

  task automatic send_addr(input logic [31:0] a);
    for (int i = 3; i >= 0; i--) host(a[8 * i +: 8]);
    send_crc(a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0]);
  endtask

  // done events until the run ends, with ignored noise mixed in
  task automatic drain_run();
    while (sb.ph >= PH_RUN_OPT) begin
      if ($urandom_range(0, 11) == 0)
        put(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      put(FN_DONE, 8'd0);
    end
  endtask

  task automatic do_read(input logic [31:0] a, input logic [7:0] n);
    command(CMD_READ);
    if (sb.ph != PH_ADDR) return;
    send_addr(a);
    if (sb.ph != PH_RD_COUNT) return;
    host(n);
    send_crc(~n);
    drain_run();
  endtask

  task automatic do_go(input logic [31:0] a);
    command(CMD_GO);
    if (sb.ph == PH_ADDR) send_addr(a);
  endtask

  task automatic do_write(input logic [31:0] a, input int n);
    logic [7:0] c, d;
    command(CMD_WRITE);
    if (sb.ph != PH_ADDR) return;
    send_addr(a);
    if (sb.ph != PH_WR_COUNT) return;
    c = 8'(n - 1);
    host(c);
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(0, 255));
      c ^= d;
      host(d);
    end
    send_crc(c);
    drain_run();
  endtask

  // plain erase: count byte, page list; 0xFF count is mass erase
  task automatic do_erase(input logic [7:0] n, input bit good_mass);
    logic [7:0] c, d;
    command(CMD_ERASE);
    if (sb.ph != PH_ER_COUNT) return;
    host(n);
    if (sb.ph == PH_MASS) begin
      host(good_mass ? 8'h00 : 8'($urandom_range(1, 255)));
      return;
    end
    if (sb.ph != PH_DATA) return;
    c = n;
    for (int i = 0; i <= n; i++) begin
      d = 8'($urandom_range(0, 255));
      c ^= d;
      host(d);
    end
    send_crc(c);
    drain_run();
  endtask

  task automatic do_exerase(input logic [15:0] n);
    logic [7:0] c, d;
    command(CMD_EXERASE);
    if (sb.ph != PH_EX_COUNT) return;
    host(n[15:8]);
    host(n[7:0]);
    if (sb.ph == PH_EX_SPECIAL) begin
      host(8'($urandom_range(0, 255)));
      return;
    end
    if (sb.ph != PH_DATA) return;
    c = n[15:8] ^ n[7:0];
    for (int i = 0; i < 2 * (int'(n) + 1); i++) begin
      d = 8'($urandom_range(0, 255));
      c ^= d;
      host(d);
    end
    send_crc(c);
    drain_run();
  endtask

  // wait out all owed results and the engine's tail before a register write
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] r, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0: return sb.base + sb.fsize - $urandom_range(1, 12);
      1: return ADDR_FSIZE;
      2: return ADDR_PID;
      3: return ADDR_OPTION;
      4: return $urandom();
      default: return sb.base + $urandom_range(0, sb.fsize - 1);
    endcase
  endfunction

  // one random command or stray event
  task automatic random_item();
    logic [31:0] a;
    a = pick_addr();
    case ($urandom_range(0, 14))
      0: command(8'($urandom_range(0, 2)));
      1: host($urandom_range(0, 1) ? SYNC_BYTE : ($urandom_range(0, 1) ? ACK_BYTE : NACK_BYTE));
      2: put(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
      3: command(8'($urandom_range(0, 255)));
      4, 5: do_read(a, a >= ADDR_PID && a <= ADDR_OPTION ?
                    8'($urandom_range(0, 1) ? 1 : 15) : 8'($urandom_range(0, 6)));
      6: do_go($urandom_range(0, 1) ? a : sb.base - $urandom_range(0, 1));
      7, 8: do_write(a & ~32'h3, $urandom_range(0, 3) == 0 ?
                     $urandom_range(1, 20) : 4 * $urandom_range(1, 4));
      9: do_erase($urandom_range(0, 9) == 0 ? 8'hFF : 8'($urandom_range(0, 3)),
                  $urandom_range(0, 3) != 0);
      10, 11: do_exerase($urandom_range(0, 9) == 0 ? 16'($urandom_range(16'hFFF0, 16'hFFFF)) :
                         ($urandom_range(0, 9) == 0 ? 16'($urandom_range(1024, 16'hFFEF)) :
                          16'($urandom_range(0, 3))));
      default: begin
        // command cut short by a receive timeout
        command(CMD_READ);
        if (sb.ph == PH_ADDR) host(8'($urandom_range(0, 255)));
        put(FN_TIMEOUT, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    logic [31:0] bases [4] = '{32'h0800_0000, 32'hFFFF_FC00, 32'h0000_0000, 32'h2000_0000};
    logic [31:0] sizes [4] = '{32'd1024, 32'd16777216, 32'd65536, 32'd131072};
    logic [31:0] shifts [4] = '{32'd7, 32'd16, 32'd10, 32'd9};
    int target;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every command, special reads, odd bytes, failures
    host(SYNC_BYTE);
    host(ACK_BYTE);
    command(CMD_GET);
    command(CMD_VERSION);
    command(CMD_ID);
    command(8'h55);
    do_read(ADDR_FSIZE, 8'd1);
    do_read(ADDR_PID, 8'd1);
    do_read(ADDR_OPTION, 8'h0F);
    do_read(32'h0000_0100, 8'd3);
    do_read(32'hFFFF_FFF0, 8'd2);
    do_go(32'h0000_0200);
    do_go(32'h0002_0000);
    do_write(32'h0000_0400, 8);
    do_write(32'h0000_0400, 6);
    do_erase(8'd2, 1'b1);
    do_erase(8'hFF, 1'b1);
    do_erase(8'hFF, 1'b0);
    do_exerase(16'd1);
    do_exerase(16'hFFFF);
    do_exerase(16'hFFF0);
    do_exerase(16'h0400);
    put(FN_TIMEOUT, 8'd0);
    put(FN_DONE, 8'd0);

    // random items under several register settings, extremes included
    for (int p = 0; p < 4; p++) begin
      settle();
      write_reg(REG_FLASH_BASE, bases[p]);
      write_reg(REG_FLASH_SIZE, sizes[p]);
      write_reg(REG_PAGE_SHIFT, shifts[p]);
      target = beats + 25;
      while (beats < target) random_item();
    end

    settle();
    repeat (30) @(posedge clk);
    if (sb.owed.size() != 0) report($sformatf("%0d results never arrived", sb.owed.size()));
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ubce_pkg.sv
design/ubce_ram.sv
design/uart_bootloader_command_engine_core.sv
bench/tb_uart_bootloader_command_engine_core.sv
